@@ rtl/core/lisl_pkg.sv @@
// Shared constants for the patience-sorting LIS length block.
`default_nettype none

package lisl_pkg;

  localparam int MaxLen     = 1024;
  localparam int ValueWidth = 32;
  localparam int AddrW      = $clog2(MaxLen);
  localparam int LenW       = AddrW + 1;

endpackage : lisl_pkg

`default_nettype wire

@@ rtl/core/lisl_if.sv @@
// Valid/ready channel interfaces for sample input and length output.
`default_nettype none

interface lisl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lisl_pkg::ValueWidth-1:0] sample;
  logic                                  start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface : lisl_in_if

interface lisl_out_if;
  logic                        valid;
  logic                        ready;
  logic [lisl_pkg::LenW-1:0]   lis_length;
  logic                        overflow;

  modport source (output valid, output lis_length, output overflow, input ready);
  modport sink   (input valid, input lis_length, input overflow, output ready);
endinterface : lisl_out_if

`default_nettype wire

@@ rtl/core/lisl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lisl_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : lisl_ram

`default_nettype wire

@@ rtl/core/lis_length_patience_tails_top.sv @@
// Top level: streaming LIS length via binary search over a tail RAM.
//
// Usage:
//   in_i  (sink)   : one word per sample; start_req marks the first sample of
//                    a new sequence and clears the running length first.
//   out_o (source) : one word per accepted sample, giving the LIS length so
//                    far and an overflow flag (append needed, table full,
//                    sample dropped; length stays at the table size).
// Search:
//   One sample at a time. The search probes the tail RAM once per cycle,
//   folding each read result into the window as it arrives; a search
//   makes ceil(log2(length + 1)) probes. The result is registered and
//   visible the cycle after the write.
// Stall:
//   The result sits in an output register; the next sample is accepted
//   while it waits. A new result is held back in the write cycle until the
//   register has been taken.
// Reset:
//   rst_ni clears the length and all control state. Tail RAM contents are
//   not cleared; only entries below the current length are ever read.
`default_nettype none

module lis_length_patience_tails_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lisl_in_if.sink     in_i,
  lisl_out_if.source  out_o
);

  localparam int AddrW = lisl_pkg::AddrW;
  localparam int LenW  = lisl_pkg::LenW;
  localparam int VW    = lisl_pkg::ValueWidth;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StWrite
  } state_e;

  state_e           state_q;
  logic [LenW-1:0]  len_q;      // tails in use
  logic [LenW-1:0]  lo_q, hi_q, mid_q;
  logic             rd_pend_q;  // a probe at mid_q is in flight
  logic [VW-1:0]    key_q;      // offset-binary sample
  logic [LenW-1:0]  pos_q;      // search result

  logic             out_valid_q;
  logic [LenW-1:0]  out_len_q;
  logic             out_ovf_q;

  // Search step signals
  logic [VW-1:0]    rd_data;
  logic             tail_less;
  logic [LenW-1:0]  lo_c, hi_c, mid_c;
  logic             probe;

  // Write step signals
  logic             out_free;
  logic             is_append;
  logic             tbl_full;
  logic             ram_we;

  logic             in_acc;

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;

  // Fold in the pending probe, then pick the next midpoint.
  assign tail_less = rd_data < key_q;
  always_comb begin
    lo_c = lo_q;
    hi_c = hi_q;
    if (rd_pend_q) begin
      if (tail_less) begin
        lo_c = mid_q + LenW'(1);
      end else begin
        hi_c = mid_q;
      end
    end
    mid_c = lo_c + ((hi_c - lo_c) >> 1);
  end
  assign probe = (state_q == StSearch) && (lo_c < hi_c);

  assign out_free  = !out_valid_q || out_o.ready;
  assign is_append = (pos_q == len_q);
  assign tbl_full  = (len_q == LenW'(lisl_pkg::MaxLen));
  assign ram_we    = (state_q == StWrite) && out_free && !(is_append && tbl_full);

  lisl_ram #(
    .Width (VW),
    .Depth (lisl_pkg::MaxLen)
  ) u_tails (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q[AddrW-1:0]),
    .wdata_i (key_q),
    .re_i    (probe),
    .raddr_i (mid_c[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      rd_pend_q   <= 1'b0;
      key_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      out_len_q   <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            key_q     <= {~in_i.sample[VW-1], in_i.sample[VW-2:0]};
            lo_q      <= '0;
            hi_q      <= in_i.start_req ? '0 : len_q;
            rd_pend_q <= 1'b0;
            if (in_i.start_req) begin
              len_q <= '0;
            end
            state_q   <= StSearch;
          end
        end
        StSearch: begin
          lo_q      <= lo_c;
          hi_q      <= hi_c;
          mid_q     <= mid_c;
          rd_pend_q <= probe;
          if (!probe) begin
            pos_q   <= lo_c;
            state_q <= StWrite;
          end
        end
        StWrite: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ovf_q   <= is_append && tbl_full;
            if (is_append && !tbl_full) begin
              len_q     <= len_q + LenW'(1);
              out_len_q <= len_q + LenW'(1);
            end else begin
              out_len_q <= len_q;
            end
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.lis_length = out_len_q;
  assign out_o.overflow   = out_ovf_q;

  // Overflow is only reported with a full table.
  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.overflow |-> out_o.lis_length == LenW'(lisl_pkg::MaxLen))
    else $error("overflow reported below full length");

  // Search window stays inside the filled part of the table.
  a_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSearch |-> lo_q <= hi_q && hi_q <= len_q)
    else $error("search window out of range");

  // A start request drops the length to zero before the search.
  a_start_clr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.start_req |=> len_q == '0 && state_q == StSearch)
    else $error("start request did not clear length");

  // Length never exceeds the table size.
  a_len_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(lisl_pkg::MaxLen))
    else $error("length beyond table size");

endmodule : lis_length_patience_tails_top

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for the LIS length block: directed and random sample streams checked per word.
`timescale 1ns / 100ps

module tb_top;

  localparam int ValueWidth = lisl_pkg::ValueWidth;
  localparam int LenW       = lisl_pkg::LenW;
  localparam int MaxLen     = lisl_pkg::MaxLen;

  // Expected output word: running LIS length and the full-table flag.
  typedef struct packed {
    logic [LenW-1:0] lis_length;
    logic            overflow;
  } lis_word_t;

  // No word may stall longer than this; it exceeds the long output hold.
  localparam int QuietLimit  = 3000;
  // Settle time after the last word.
  localparam int SettleCycles = 40;
  localparam int HoldCycles   = 300;
  localparam logic signed [ValueWidth-1:0] ValMin = {1'b1, {(ValueWidth-1){1'b0}}};
  localparam logic signed [ValueWidth-1:0] ValMax = {1'b0, {(ValueWidth-1){1'b1}}};

  logic clk_i;
  logic rst_ni;

  lisl_in_if  in_if ();
  lisl_out_if out_if ();

  lis_length_patience_tails_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state: its own tail table and running length.
  logic signed [ValueWidth-1:0] tail_mem [MaxLen];
  logic [LenW-1:0]              pred_len = '0;

  // Lengths still owed by the block, oldest first.
  lis_word_t length_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len      = 0;
  int hold_token    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  int items_sent     = 0;
  int seqs_started   = 0;
  int words_checked  = 0;
  int overflow_words = 0;
  int mismatches     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Patience step: find the first tail not less than the value, then either
  // append (length grows) or replace. Append on a full table drops the value.
  function automatic lis_word_t lis_predict(input logic signed [ValueWidth-1:0] value,
                                            input logic first);
    int        lo;
    int        hi;
    int        mid;
    lis_word_t w;
    if (first) pred_len = '0;
    lo = 0;
    hi = int'(pred_len);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tail_mem[mid] < value) lo = mid + 1;
      else hi = mid;
    end
    w.overflow = 1'b0;
    if (lo == int'(pred_len)) begin
      if (int'(pred_len) < MaxLen) begin
        tail_mem[lo] = value;
        pred_len     = pred_len + 1'b1;
      end else begin
        w.overflow = 1'b1;
      end
    end else begin
      tail_mem[lo] = value;
    end
    w.lis_length = pred_len;
    return w;
  endfunction

  // Offer one sample, with a random gap first; valid stays high into the
  // next call when there is no gap, so it is never lowered and raised in one step.
  task automatic send_sample(input logic signed [ValueWidth-1:0] value, input logic first);
    int gap;
    gap = 0;
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) gap++;
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample    <= value;
    in_if.start_req <= first;
    do @(posedge clk_i); while (!in_if.ready);
    length_q.insert(length_q.size(), lis_predict(value, first));
    items_sent++;
    if (first) seqs_started++;
  endtask

  // Sender pause: drop valid and wait for every owed word.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (length_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_value_extremes();
    send_sample('0, 1'b0);       // first word after reset, no start flag
    send_sample(ValMin, 1'b1);
    send_sample(ValMax, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(0, 1'b0);
    send_sample(1, 1'b0);
    send_sample(ValMax, 1'b0);
    send_sample(ValMin, 1'b0);
    send_sample(32'h5555_5555, 1'b0);
    send_sample(32'hAAAA_AAAA, 1'b0);
    wait_for_results();
  endtask

  // Equal values replace their own tail; the length must not grow.
  task automatic test_equal_values();
    send_sample(5, 1'b1);
    send_sample(5, 1'b0);
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(5, 1'b0);
    send_sample(6, 1'b0);
    send_sample(7, 1'b0);
    wait_for_results();
  endtask

  // Decreasing run keeps length 1; start flags back to back restart each time.
  task automatic test_restart();
    send_sample(ValMax, 1'b1);
    send_sample(100, 1'b0);
    send_sample(-100, 1'b0);
    send_sample(ValMin, 1'b0);
    send_sample(ValMin, 1'b1);
    send_sample(0, 1'b1);
    send_sample(1, 1'b0);
    wait_for_results();
  endtask

  // Receiver holds off long while the sender keeps offering: the output
  // register fills and the input stalls until the hold ends.
  task automatic test_output_stall();
    hold_len   = HoldCycles;
    hold_token = hold_token + 1;
    send_sample($urandom, 1'b1);
    for (int i = 0; i < 7; i++) send_sample($urandom, 1'b0);
    wait_for_results();
  endtask

  // Mostly well-formed sequences with random content, plus noise and
  // sequences cut by a restart halfway.
  task automatic test_random_stream(input int budget);
    int                           count;
    int                           kind;
    int                           len;
    int                           style;
    logic                         first;
    logic signed [ValueWidth-1:0] cur;
    logic signed [ValueWidth-1:0] value;
    count = 0;
    while (count < budget) begin
      kind  = $urandom_range(9);
      style = $urandom_range(3);
      if ($urandom_range(19) == 0) len = $urandom_range(100, 300);
      else len = $urandom_range(1, 24);
      if (len > budget - count) len = budget - count;
      cur = $urandom_range(1, 0) ? ValMin + $urandom_range(1000) : $urandom;
      for (int i = 0; i < len; i++) begin
        case (style)
          0: value = $urandom;
          1: value = $urandom_range(16) - 8;
          2: begin
            // rising walk with occasional steps back
            cur   = cur + $urandom_range(3000) - 500;
            value = cur;
          end
          default: begin
            case ($urandom_range(4))
              0: value = ValMin;
              1: value = ValMax;
              2: value = 0;
              3: value = -1;
              default: value = $urandom;
            endcase
          end
        endcase
        if (kind <= 6) first = (i == 0);
        else if (kind <= 8) first = 1'($urandom_range(1));
        else first = (i == 0) || (i == len / 2);
        send_sample(value, first);
        count++;
      end
    end
    wait_for_results();
  endtask

  // Receiver: random ready, or a long hold when the test asks for one.
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted word with the oldest expectation.
  always @(posedge clk_i) begin
    lis_word_t exp_w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_checked++;
      if (out_if.overflow) overflow_words++;
      if (length_q.size() == 0) begin
        $error("unexpected word: lis_length %0d overflow %0b",
               out_if.lis_length, out_if.overflow);
        mismatches++;
      end else begin
        exp_w = length_q.pop_front();
        if (out_if.lis_length !== exp_w.lis_length) begin
          $error("lis_length mismatch: expected %0d, got %0d",
                 exp_w.lis_length, out_if.lis_length);
          mismatches++;
        end
        if (out_if.overflow !== exp_w.overflow) begin
          $error("overflow mismatch: expected %0b, got %0b",
                 exp_w.overflow, out_if.overflow);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either side ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("watchdog: no word moved for %0d cycles, %0d still owed",
                   quiet_cycles, length_q.size());
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.sample    = '0;
    in_if.start_req = 1'b0;
    out_if.ready    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 28;
    recv_idle_pct = 78;
    test_value_extremes();
    test_equal_values();
    test_restart();
    test_random_stream(205);

    // Roles swapped.
    send_idle_pct = 78;
    recv_idle_pct = 28;
    test_random_stream(205);

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    test_random_stream(205);

    in_if.valid <= 1'b0;
    while (length_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d samples in %0d sequences; checked %0d length words, %0d with overflow.",
             items_sent, seqs_started, words_checked, overflow_words);
    $display("Covered value extremes, equal values, restarts, random streams and a long stall.");
    if (mismatches == 0 && length_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/lisl_pkg.sv
rtl/core/lisl_if.sv
rtl/core/lisl_ram.sv
rtl/core/lis_length_patience_tails_top.sv
tb/tb_top.sv
